/* sv/assert_macros.svh */
// Assertion helpers, clocked on clk_i and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define SDP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define SDP_ASSERT_IMPL(lbl, ante, cons, msg) \
  `SDP_ASSERT(lbl, (ante) |-> (cons), msg)

`define SDP_ASSERT_NEXT(lbl, ante, cons, msg) \
  `SDP_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

/* sv/sdp_pkg.sv */
package sdp_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned ValueW = 32;

  localparam logic [CharW-1:0] CharNul    = 8'h00;
  localparam logic [CharW-1:0] SignPivot  = 8'd44;
  localparam logic [CharW-1:0] CharPlus   = SignPivot - 8'd1;
  localparam logic [CharW-1:0] CharMinus  = SignPivot + 8'd1;
  localparam logic [CharW-1:0] CharZero   = 8'h30;
  localparam logic [CharW-1:0] CharNine   = 8'h39;
  localparam logic [CharW-1:0] CharTab    = 8'h09;
  localparam logic [CharW-1:0] CharCr     = 8'h0d;
  localparam logic [CharW-1:0] CharSpace  = 8'h20;

  // Overflow limits before the multiply by ten
  localparam logic signed [ValueW-1:0] PosLimit = 32'sd214748364;
  localparam logic signed [ValueW-1:0] NegLimit = -32'sd214748364;
  localparam logic [3:0]               PosLastDigit = 4'd7;
  localparam logic [3:0]               NegLastDigit = 4'd8;

  typedef enum logic [1:0] {
    PH_LEAD   = 2'b01,
    PH_DIGITS = 2'b10
  } phase_e;

endpackage

/* sv/sdp_intf.sv */
interface sdp_in_if;
  import sdp_pkg::*;

  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface sdp_out_if;
  import sdp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] value;
  logic                     error;

  modport source (output valid, output value, output error, input ready);
  modport sink (input valid, input value, input error, output ready);
endinterface

/* sv/signed_decimal_parser_core.sv */
// A terminator beat shows its result on the output in the cycle after acceptance.
// Throughput: one byte per cycle; the single output register accepts a new beat
// in the cycle its held result is taken, so input ready stalls only on output backpressure.
// Reset (rst_ni, async, active low): lead phase, sign, accumulator, error flag and
// output valid clear; the parse state also returns to that state after every terminator.
`include "assert_macros.svh"

module signed_decimal_parser_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  sdp_in_if.sink    in_i,
  sdp_out_if.source out_o
);
  import sdp_pkg::*;

  phase_e                   phase_q, phase_d;
  logic                     negative_q, negative_d;
  logic signed [ValueW-1:0] acc_q, acc_d;
  logic                     failed_q, failed_d;

  logic                     out_valid_q, out_valid_d;
  logic signed [ValueW-1:0] value_q, value_d;
  logic                     error_q, error_d;

  logic                     in_fire;
  logic                     is_term;
  logic                     is_ws;
  logic                     is_sign;
  logic                     is_digit;
  logic                     in_lead;
  logic [3:0]               digit;
  logic                     ovf;
  logic signed [ValueW-1:0] acc_x10;
  logic signed [ValueW-1:0] acc_next;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  assign is_term  = (in_i.char_code == CharNul);
  assign is_ws    = (in_i.char_code == CharSpace) ||
                    ((in_i.char_code >= CharTab) && (in_i.char_code <= CharCr));
  assign is_sign  = (in_i.char_code == CharPlus) || (in_i.char_code == CharMinus);
  assign is_digit = (in_i.char_code >= CharZero) && (in_i.char_code <= CharNine);
  assign digit    = 4'(in_i.char_code - CharZero);

  always_comb begin
    case (phase_q)
      PH_LEAD: in_lead = 1'b1;
      default: in_lead = 1'b0;
    endcase
  end

  always_comb begin
    if (negative_q) begin
      ovf = (acc_q < NegLimit) || ((acc_q == NegLimit) && (digit > NegLastDigit));
    end else begin
      ovf = (acc_q > PosLimit) || ((acc_q == PosLimit) && (digit > PosLastDigit));
    end
  end

  assign acc_x10  = (acc_q <<< 3) + (acc_q <<< 1);
  assign acc_next = negative_q ? (acc_x10 - $signed({28'd0, digit}))
                               : (acc_x10 + $signed({28'd0, digit}));

  always_comb begin
    phase_d    = phase_q;
    negative_d = negative_q;
    acc_d      = acc_q;
    failed_d   = failed_q;
    if (in_fire) begin
      if (is_term) begin
        phase_d    = PH_LEAD;
        negative_d = 1'b0;
        acc_d      = '0;
        failed_d   = 1'b0;
      end else if (!failed_q) begin
        if (in_lead && is_ws) begin
          phase_d = phase_q;
        end else if (in_lead && is_sign) begin
          negative_d = (in_i.char_code == CharMinus);
          phase_d    = PH_DIGITS;
        end else begin
          phase_d = PH_DIGITS;
          if (!is_digit || ovf) begin
            failed_d = 1'b1;
          end else begin
            acc_d = acc_next;
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    value_d     = value_q;
    error_d     = error_q;
    if (in_fire && is_term) begin
      out_valid_d = 1'b1;
      value_d     = failed_q ? '0 : acc_q;
      error_d     = failed_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEAD;
      negative_q  <= 1'b0;
      acc_q       <= '0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      negative_q  <= negative_d;
      acc_q       <= acc_d;
      failed_q    <= failed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    error_q <= error_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.value = value_q;
  assign out_o.error = error_q;

  `SDP_ASSERT_IMPL(a_err_zero, out_valid_q && error_q, value_q == '0, "error result with nonzero value")
  `SDP_ASSERT_NEXT(a_term_clear, in_fire && is_term, out_valid_q && (acc_q == '0) && !failed_q && (phase_q == PH_LEAD) && !negative_q, "terminator did not clear state")
  `SDP_ASSERT_IMPL(a_pos_sign, !negative_q, !acc_q[ValueW-1], "positive accumulator went negative")
  `SDP_ASSERT_NEXT(a_fail_hold, failed_q && !(in_fire && is_term), failed_q && $stable(acc_q), "accumulator moved after failure")

endmodule
